// ===== hdl/pat_pkg.sv =====
// Shared types, status and kind codes for the pending ack tracker.
`timescale 1ns / 1ps
package pat_pkg;
  localparam int ENTRIES_DEF     = 32;
  localparam int ORDER_DEPTH_DEF = 64;
  localparam int IdW    = 64;
  localparam int TimeW  = 64;
  localparam int HdlW   = 32;
  localparam int KindW  = 3;
  localparam int StatW  = 3;

  localparam logic [KindW-1:0] K_PUSH   = 3'd0;
  localparam logic [KindW-1:0] K_ACK    = 3'd1;
  localparam logic [KindW-1:0] K_SWEEP  = 3'd2;
  localparam logic [KindW-1:0] K_CLEAR  = 3'd3;
  localparam logic [KindW-1:0] K_REMOVE = 3'd4;

  localparam logic [StatW-1:0] ST_OK       = 3'd0;
  localparam logic [StatW-1:0] ST_NOTFOUND = 3'd1;
  localparam logic [StatW-1:0] ST_DUP      = 3'd2;
  localparam logic [StatW-1:0] ST_FULL     = 3'd3;
  localparam logic [StatW-1:0] ST_EXPIRED  = 3'd4;
  localparam logic [StatW-1:0] ST_FLUSHED  = 3'd5;
  localparam logic [StatW-1:0] ST_EMPTY    = 3'd6;

  // control word broadcast to every slot cell
  typedef struct packed {
    logic         match_en;   // compare key against the stored id
    logic         kill_hit;   // drop the matching live entry
    logic         kill_sel;   // drop the entry named by sel
    logic         kill_all;   // drop all entries
    logic         write_en;   // store into the first free cell
  } cell_ctl_t;
endpackage

// ===== hdl/pat_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module pat_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/pat_cell.sv =====
// One slot of the live table: valid bit, id, handle, and a free-slot chain link.
`timescale 1ns / 1ps
module pat_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  pat_pkg::cell_ctl_t       ctl,
  input  logic                     sel,
  input  logic [pat_pkg::IdW-1:0]  key,
  input  logic [pat_pkg::HdlW-1:0] wr_handle,
  input  logic                     free_in,   // a cell to the left is free
  output logic                     free_out,
  output logic                     hit,
  output logic                     valid,
  output logic [pat_pkg::IdW-1:0]  id,
  output logic [pat_pkg::HdlW-1:0] handle
);
  import pat_pkg::*;
  logic                valid_r, valid_nxt;
  logic [IdW-1:0]      id_r;
  logic [HdlW-1:0]     handle_r;
  logic                take;

  assign hit      = valid_r && (id_r == key);
  assign take     = ctl.write_en && !valid_r && !free_in;
  assign free_out = free_in || !valid_r;
  assign valid    = valid_r;
  assign id       = id_r;
  assign handle   = handle_r;

  always_comb begin
    valid_nxt = valid_r;
    if (take) valid_nxt = 1'b1;
    if ((ctl.kill_hit && hit) || (ctl.kill_sel && sel) || ctl.kill_all) valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      id_r     <= key;
      handle_r <= wr_handle;
    end
  end
endmodule

// ===== hdl/pending_ack_tracker_with_timeout.sv =====
// Top level of the pending ack tracker: slot cell row, order ring and sequencer.
`timescale 1ns / 1ps
// Pending ack tracker. A row of ENTRIES slot cells holds live (id, handle)
// entries. Every cell compares its id against the broadcast key in parallel,
// and a free-slot chain picks the lowest free cell for a push. An order ring
// of ORDER_DEPTH (id, time) records sits in two RAMs with registered reads.
// One item is worked at a time: in_ready is high only while the sequencer is
// idle and the output word register is empty. Push, ack and remove match the
// key in S_KEY and load the result word as it ends; the next item is taken
// once that word has left the output register. A push into a full ring first
// compacts it: S_CRD reads each record, S_CMAT matches it and rewrites it if
// its id is still live, S_CRD closes the pass and S_PUSH2 stores the push.
// A sweep takes each record that it pops through ring read, time check and
// key match (S_SRD, S_SCHK, S_SMAT) and stops at an empty ring or a record
// past the deadline. A clear or an all-ones sweep walks the slots, one per
// cycle but for the stalls below; both then give their final word in S_FIN.
// Expired and flushed words are held one step in a pending register so the
// final word of a sweep or flush can carry last. A flush stalls only when a
// live slot is found while the word before it waits on out_ready; a sweep
// waits at a ring read while a word is held and another is unsent. Unused
// kinds give no result; an empty sweep or flush gives one sweep-empty word.
module pending_ack_tracker_with_timeout #(
  parameter int ENTRIES     = pat_pkg::ENTRIES_DEF,
  parameter int ORDER_DEPTH = pat_pkg::ORDER_DEPTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pat_pkg::KindW-1:0] in_kind,
  input  logic [pat_pkg::IdW-1:0]   in_msg_id,
  input  logic [pat_pkg::TimeW-1:0] in_send_time_ms,
  input  logic [pat_pkg::HdlW-1:0]  in_msg_handle,
  input  logic [pat_pkg::TimeW-1:0] in_deadline_ms,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [pat_pkg::StatW-1:0] out_status,
  output logic [pat_pkg::IdW-1:0]   out_out_id,
  output logic [pat_pkg::HdlW-1:0]  out_out_handle,
  output logic                      out_last
);
  import pat_pkg::*;

  localparam int SW = $clog2(ENTRIES);
  localparam int RW = $clog2(ORDER_DEPTH);
  localparam int CW = $clog2(ORDER_DEPTH + 1);
  localparam logic [CW-1:0] RING_FULL = CW'(ORDER_DEPTH);
  localparam logic [SW-1:0] SLOT_LAST = SW'(ENTRIES - 1);
  localparam logic [TimeW-1:0] ALL_ONES = '1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_KEY   = 4'd1;  // cells compare the input id
  localparam logic [3:0] S_SRD   = 4'd2;  // sweep: ring read issued
  localparam logic [3:0] S_SCHK  = 4'd3;  // sweep: record data present
  localparam logic [3:0] S_SMAT  = 4'd4;  // sweep: cells match record id
  localparam logic [3:0] S_FLUSH = 4'd5;
  localparam logic [3:0] S_CRD   = 4'd6;  // compact: read
  localparam logic [3:0] S_CMAT  = 4'd7;  // compact: match and rewrite
  localparam logic [3:0] S_PUSH2 = 4'd8;  // push after compaction
  localparam logic [3:0] S_FIN   = 4'd9;  // sweep or flush: final word

  logic [3:0]      state_r, state_nxt;
  logic [KindW-1:0] kind_r;
  logic [IdW-1:0]  id_r;
  logic [TimeW-1:0] time_r, dl_r;
  logic [HdlW-1:0] hdl_r;
  logic [RW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   k_r, k_nxt, w_r, w_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;

  // output register
  logic            ov_r, ov_nxt;
  logic [StatW-1:0] os_r, os_nxt;
  logic [IdW-1:0]  oi_r, oi_nxt;
  logic [HdlW-1:0] oh_r, oh_nxt;
  logic            ol_r, ol_nxt;

  // pending word of a sweep or flush, released once the next step shows
  // whether it is the last one
  logic            pend_r, pend_nxt;
  logic [StatW-1:0] p_stat_r, p_stat_nxt;
  logic [IdW-1:0]  p_id_r, p_id_nxt;
  logic [HdlW-1:0] p_hdl_r, p_hdl_nxt;

  // cell row
  cell_ctl_t              ctl;
  logic [IdW-1:0]         key;
  logic [ENTRIES-1:0]     hit, valid, sel;
  logic [ENTRIES:0]       free_chain;
  logic [IdW-1:0]         c_id  [ENTRIES];
  logic [HdlW-1:0]        c_hdl [ENTRIES];
  logic                   any_hit, full_tab;
  logic [IdW-1:0]         hit_id;
  logic [HdlW-1:0]        hit_hdl;

  // ring
  logic            r_we;
  logic [RW-1:0]   r_waddr, r_raddr;
  logic [IdW-1:0]  r_wid, r_rid;
  logic [TimeW-1:0] r_wtime, r_rtime;

  assign free_chain[0] = 1'b0;
  genvar g;
  generate
    for (g = 0; g < ENTRIES; g++) begin : g_cell
      assign sel[g] = (slot_r == SW'(g));
      pat_cell u_cell (
        .clk, .rst_n, .ctl, .sel(sel[g]), .key, .wr_handle(hdl_r),
        .free_in(free_chain[g]), .free_out(free_chain[g+1]),
        .hit(hit[g]), .valid(valid[g]), .id(c_id[g]), .handle(c_hdl[g])
      );
    end
  endgenerate

  assign any_hit  = |hit;
  assign full_tab = !free_chain[ENTRIES];

  // ids are unique among live cells, so an OR of masked fields selects the hit
  always_comb begin
    hit_id  = '0;
    hit_hdl = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_id  = hit_id  | (c_id[i]  & {IdW{hit[i]}});
      hit_hdl = hit_hdl | (c_hdl[i] & {HdlW{hit[i]}});
    end
  end

  pat_ram #(.WIDTH(IdW), .DEPTH(ORDER_DEPTH)) u_ring_id (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wid), .raddr(r_raddr), .rdata(r_rid));
  pat_ram #(.WIDTH(TimeW), .DEPTH(ORDER_DEPTH)) u_ring_time (
    .clk, .we(r_we), .waddr(r_waddr), .wdata(r_wtime), .raddr(r_raddr), .rdata(r_rtime));

  assign in_ready       = (state_r == S_IDLE) && !ov_r;
  assign out_valid      = ov_r;
  assign out_status     = os_r;
  assign out_out_id     = oi_r;
  assign out_out_handle = oh_r;
  assign out_last       = ol_r;

  function automatic logic [RW-1:0] ring_pos(input logic [RW-1:0] h, input logic [CW-1:0] k);
    logic [CW:0] s;
    s = {1'b0, CW'(h)} + {1'b0, k};
    if (s >= (CW+1)'(ORDER_DEPTH)) s = s - (CW+1)'(ORDER_DEPTH);
    return RW'(s);
  endfunction

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    count_nxt   = count_r;
    k_nxt       = k_r;
    w_nxt       = w_r;
    slot_nxt    = slot_r;
    ov_nxt = ov_r; os_nxt = os_r; oi_nxt = oi_r; oh_nxt = oh_r; ol_nxt = ol_r;
    pend_nxt = pend_r; p_stat_nxt = p_stat_r; p_id_nxt = p_id_r; p_hdl_nxt = p_hdl_r;
    ctl     = '0;
    key     = id_r;
    r_we    = 1'b0;
    r_waddr = ring_pos(head_r, count_r);
    r_wid   = id_r;
    r_wtime = time_r;
    r_raddr = head_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          case (in_kind)
            K_PUSH, K_ACK, K_REMOVE: state_nxt = S_KEY;
            K_SWEEP: begin
              if (in_deadline_ms == ALL_ONES) begin
                slot_nxt = '0; state_nxt = S_FLUSH;
              end else begin
                state_nxt = S_SRD;
              end
            end
            K_CLEAR: begin slot_nxt = '0; state_nxt = S_FLUSH; end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_KEY: begin
        ov_nxt = 1'b1; oi_nxt = id_r; oh_nxt = '0; ol_nxt = 1'b1;
        state_nxt = S_IDLE;
        if (kind_r == K_PUSH) begin
          if (id_r == IdW'(0) || id_r == IdW'(1) || any_hit) begin
            os_nxt = ST_DUP;
          end else if (full_tab) begin
            os_nxt = ST_FULL;
          end else if (count_r == RING_FULL) begin
            ov_nxt = 1'b0; k_nxt = '0; w_nxt = '0; state_nxt = S_CRD;
          end else begin
            os_nxt = ST_OK; ctl.write_en = 1'b1; r_we = 1'b1;
            count_nxt = count_r + CW'(1);
          end
        end else if (any_hit) begin
          os_nxt = ST_OK; ctl.kill_hit = 1'b1;
          if (kind_r == K_ACK) oh_nxt = hit_hdl;
        end else begin
          os_nxt = ST_NOTFOUND;
        end
      end
      S_CRD: begin
        if (k_r == count_r) begin
          count_nxt = w_r; state_nxt = S_PUSH2;
        end else begin
          r_raddr = ring_pos(head_r, k_r); state_nxt = S_CMAT;
        end
      end
      S_CMAT: begin
        key = r_rid;
        if (any_hit) begin
          r_we = 1'b1; r_waddr = ring_pos(head_r, w_r); r_wid = r_rid; r_wtime = r_rtime;
          w_nxt = w_r + CW'(1);
        end
        k_nxt = k_r + CW'(1); state_nxt = S_CRD;
      end
      S_PUSH2: begin
        ov_nxt = 1'b1; oi_nxt = id_r; oh_nxt = '0; ol_nxt = 1'b1; state_nxt = S_IDLE;
        if (count_r == RING_FULL) begin
          os_nxt = ST_FULL;
        end else begin
          os_nxt = ST_OK; ctl.write_en = 1'b1; r_we = 1'b1;
          count_nxt = count_r + CW'(1);
        end
      end
      S_SRD: begin
        // a held word needs the output register free before the next match
        if (count_r == '0) begin
          state_nxt = S_FIN;
        end else if (!(pend_r && ov_r)) begin
          state_nxt = S_SCHK;
        end
      end
      S_SCHK: begin
        if (r_rtime > dl_r) state_nxt = S_FIN;
        else                state_nxt = S_SMAT;
      end
      S_SMAT: begin
        key = r_rid;
        head_nxt  = ring_pos(head_r, CW'(1));
        count_nxt = count_r - CW'(1);
        state_nxt = S_SRD;
        if (any_hit) begin
          ctl.kill_hit = 1'b1;
          // release the held word, it is not the last one
          if (pend_r) begin
            ov_nxt = 1'b1; os_nxt = p_stat_r; oi_nxt = p_id_r; oh_nxt = p_hdl_r;
            ol_nxt = 1'b0;
          end
          pend_nxt = 1'b1; p_stat_nxt = ST_EXPIRED; p_id_nxt = hit_id; p_hdl_nxt = hit_hdl;
        end
      end
      S_FLUSH: begin
        // hold on a live slot while the previous word still waits
        if (!(valid[slot_r] && pend_r && ov_r)) begin
          if (valid[slot_r]) begin
            ctl.kill_sel = 1'b1;
            if (pend_r) begin
              ov_nxt = 1'b1; os_nxt = p_stat_r; oi_nxt = p_id_r; oh_nxt = p_hdl_r;
              ol_nxt = 1'b0;
            end
            pend_nxt = 1'b1; p_stat_nxt = ST_FLUSHED;
            p_id_nxt = c_id[slot_r]; p_hdl_nxt = c_hdl[slot_r];
          end
          if (slot_r == SLOT_LAST) begin
            head_nxt = '0; count_nxt = '0; state_nxt = S_FIN;
          end else begin
            slot_nxt = slot_r + SW'(1);
          end
        end
      end
      S_FIN: begin
        // emit the held word as last, or a sweep-empty word if none
        if (!ov_r) begin
          ov_nxt = 1'b1; ol_nxt = 1'b1; pend_nxt = 1'b0; state_nxt = S_IDLE;
          if (pend_r) begin
            os_nxt = p_stat_r; oi_nxt = p_id_r; oh_nxt = p_hdl_r;
          end else begin
            os_nxt = ST_EMPTY; oi_nxt = '0; oh_nxt = '0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      head_r  <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
      pend_r  <= 1'b0;
      slot_r  <= '0;
      k_r     <= '0;
      w_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      pend_r    <= pend_nxt;
      slot_r    <= slot_nxt;
      k_r       <= k_nxt;
      w_r       <= w_nxt;
      ov_r      <= ov_nxt;
    end
    os_r <= os_nxt; oi_r <= oi_nxt; oh_r <= oh_nxt; ol_r <= ol_nxt;
    p_stat_r <= p_stat_nxt; p_id_r <= p_id_nxt; p_hdl_r <= p_hdl_nxt;
    if (in_valid && in_ready) begin
      kind_r <= in_kind; id_r <= in_msg_id; time_r <= in_send_time_ms;
      hdl_r <= in_msg_handle; dl_r <= in_deadline_ms;
    end
  end

  a_ring_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= RING_FULL) else $error("ring count overflow");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !in_ready) else $error("accept while busy");
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FLUSH) ##1 (state_r == S_FIN) |-> (count_r == '0))
    else $error("flush left ring records");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable({out_status, out_out_id, out_out_handle, out_last})))
    else $error("result word changed while waiting");
  a_release_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SMAT && pend_r) |-> !ov_r)
    else $error("held word released into a busy output");
endmodule
